// File: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue; depends on nothing.
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int REQ_W   = 3;
    localparam int ST_W    = 2;
    localparam int PORT_W  = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd6;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // latch the incoming item
        logic exec;       // update pointers, write or read the store, set status
        logic take_ram;   // capture the store's read data as the result word
    } t_dq_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read; // latched item reads a live entry
    } t_dq_stat;

endpackage

// File: rtl/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by deq_datapath for the entry store.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/deq_datapath.sv
// Datapath of the double-ended queue: request latch, ring pointers, entry store
// and result registers. Depends on deq_pkg and deq_ram.
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  deq_pkg::t_dq_cmd            i_cmd,
    output deq_pkg::t_dq_stat           o_stat,
    input  logic [deq_pkg::REQ_W-1:0]   i_req_type,
    input  logic [deq_pkg::PORT_W-1:0]  i_push_word,
    output logic [deq_pkg::ST_W-1:0]    o_status,
    output logic [deq_pkg::PORT_W-1:0]  o_read_word
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);

    logic [deq_pkg::REQ_W-1:0]  r_req;
    logic [WORD_WIDTH-1:0]      r_word;
    logic [IW-1:0]              r_front, n_front;
    logic [CW-1:0]              r_count, n_count;
    logic [deq_pkg::ST_W-1:0]   r_status, n_status;
    logic [deq_pkg::PORT_W-1:0] r_rdword;

    logic [63:0]           push_ext;
    logic [63:0]           rd_ext;
    logic [WORD_WIDTH-1:0] ram_rdata;
    logic                  full, empty;
    logic                  is_push, is_read;
    logic [IW-1:0]         front_dec, front_inc;
    logic [SW-1:0]         tail_sum, last_sum;
    logic [IW-1:0]         tail_idx, last_idx;
    logic                  wr_en, rd_en;
    logic [IW-1:0]         wr_addr, rd_addr;

    assign push_ext = 64'(i_push_word);

    assign full    = (r_count == DEPTH_CNT);
    assign empty   = (r_count == '0);
    assign is_push = (r_req == deq_pkg::REQ_PUSH_FRONT) || (r_req == deq_pkg::REQ_PUSH_BACK);
    assign is_read = (r_req == deq_pkg::REQ_POP_FRONT)  || (r_req == deq_pkg::REQ_POP_BACK)
                  || (r_req == deq_pkg::REQ_PEEK_FRONT) || (r_req == deq_pkg::REQ_PEEK_BACK);

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + IW'(1);

    // Non-empty, both sums are below 2*DEPTH; one conditional subtract wraps them.
    assign tail_sum = SW'(r_front) + SW'(r_count);
    assign last_sum = tail_sum - SW'(1);
    always_comb begin
        tail_idx = (tail_sum >= DEPTH_SUM) ? IW'(tail_sum - DEPTH_SUM) : IW'(tail_sum);
        last_idx = (last_sum >= DEPTH_SUM) ? IW'(last_sum - DEPTH_SUM) : IW'(last_sum);
    end

    assign o_stat.needs_read = is_read && !empty;

    assign wr_en   = i_cmd.exec && is_push && !full;
    assign wr_addr = (r_req == deq_pkg::REQ_PUSH_FRONT) ? front_dec : tail_idx;
    assign rd_en   = i_cmd.exec && is_read && !empty;
    assign rd_addr = ((r_req == deq_pkg::REQ_POP_BACK) || (r_req == deq_pkg::REQ_PEEK_BACK))
                   ? last_idx : r_front;

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        unique case (r_req)
            deq_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::REQ_PEEK_FRONT, deq_pkg::REQ_PEEK_BACK: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end
            end
            deq_pkg::REQ_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                // The unused code leaves everything as it is.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    assign rd_ext = 64'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req_type;
            r_word <= push_ext[WORD_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rdword <= '0;
        end else if (i_cmd.take_ram) begin
            r_rdword <= rd_ext[deq_pkg::PORT_W-1:0];
        end
    end

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    assign o_status    = r_status;
    assign o_read_word = r_rdword;

endmodule

// File: rtl/deq_ctrl.sv
// Controller of the double-ended queue: sequences accept, execute and store
// read, and owns the result valid flag. Depends on deq_pkg.
module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    input  deq_pkg::t_dq_stat  i_stat,
    output deq_pkg::t_dq_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   slot_free;
    logic   take;

    // The result register may be refilled in the cycle its item leaves.
    assign slot_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.load_req = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.take_ram = 1'b0;
        take           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.needs_read) begin
                        n_state = S_READ;
                    end else begin
                        take    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (slot_free) begin
                    o_cmd.take_ram = 1'b1;
                    take           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rsp_valid = take || (r_rsp_valid && !i_rsp_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue: bounded deque in a ring buffer.
// Depends on deq_pkg, deq_ctrl, deq_datapath and deq_ram.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready) carries i_req_type and
//   i_push_word. Response channel (o_rsp_valid / i_rsp_ready) carries
//   o_status and o_read_word, exactly one response per request, in order.
//   Requests are handled one at a time. A request is taken in the idle
//   state and executed in the execute state once the output register is
//   free; pushes, clear, errors and the unused code present their response
//   from the execute state, pops and peeks from the store-read state that
//   follows it, as the entry store has a registered read port. A new request
//   is accepted only after the controller is back in the idle state.
//   The finished response sits in an output register, so the next request is
//   accepted while the previous response is still waiting. If the receiver
//   stalls, execution of the following request waits until the output
//   register is free.
//   Reset empties the queue (front index and count to zero). The entry
//   storage is not cleared; only live entries are ever read.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [deq_pkg::REQ_W-1:0]   i_req_type,
    input  logic [deq_pkg::PORT_W-1:0]  i_push_word,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [deq_pkg::ST_W-1:0]    o_status,
    output logic [deq_pkg::PORT_W-1:0]  o_read_word
);

    deq_pkg::t_dq_cmd  cmd;
    deq_pkg::t_dq_stat stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_type  (i_req_type),
        .i_push_word (i_push_word),
        .o_status    (o_status),
        .o_read_word (o_read_word)
    );

    // Only one request is in flight: acceptance closes the request channel.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another is in flight");

    // Every error response carries a zero word.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_status != deq_pkg::ST_OK)) |-> (o_read_word == '0))
        else $error("error response with non-zero data");

    // Status is always one of the defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_status == deq_pkg::ST_OK || o_status == deq_pkg::ST_EMPTY
                         || o_status == deq_pkg::ST_FULL))
        else $error("undefined status code");

    // A store read is followed by capture of its data before any new request.
    a_read_then_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec && stat.needs_read) |=> (!o_req_ready && !cmd.exec))
        else $error("store read not followed by data capture");

endmodule
